// File: sv/bge_pkg.sv
// Shared types, codes and character constants for the bracket group extractor.
// Depends on nothing; imported by bracket_group_extractor.
package bge_pkg;

    // Defaults for the top-level parameters.
    localparam int STACK_DEPTH_DEF = 64;
    localparam int POS_BITS_DEF    = 16;

    // Fixed port widths.
    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int EVENT_W = 3;
    localparam int ERR_W   = 2;
    localparam int POS_W   = 16;

    // Character constants.
    localparam logic [CHAR_W-1:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_NEWLINE      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE        = 8'h20;

    // Item commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_CHAR    = 2'd0,
        CMD_EOL     = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    // Bracket kinds as kept on the stack.
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_ROUND  = 2'd1,
        KIND_CURLY  = 2'd2,
        KIND_SQUARE = 2'd3
    } t_kind;

    // Event codes reported with each result.
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE         = 3'd0,
        EV_OPEN_ROUND   = 3'd1,
        EV_OPEN_CURLY   = 3'd2,
        EV_OPEN_SQUARE  = 3'd3,
        EV_CLOSE        = 3'd4,
        EV_ERROR        = 3'd5
    } t_event;

    // Error kinds.
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_MISMATCH = 2'd1,
        ERR_DEEP     = 2'd2
    } t_err;

    // Kind of an opening bracket, or none.
    function automatic t_kind open_kind(input logic [CHAR_W-1:0] c);
        t_kind k;
        k = KIND_NONE;
        if (c == CH_OPEN_ROUND) begin
            k = KIND_ROUND;
        end else if (c == CH_OPEN_CURLY) begin
            k = KIND_CURLY;
        end else if (c == CH_OPEN_SQUARE) begin
            k = KIND_SQUARE;
        end
        return k;
    endfunction

    // Kind of a closing bracket, or none.
    function automatic t_kind close_kind(input logic [CHAR_W-1:0] c);
        t_kind k;
        k = KIND_NONE;
        if (c == CH_CLOSE_ROUND) begin
            k = KIND_ROUND;
        end else if (c == CH_CLOSE_CURLY) begin
            k = KIND_CURLY;
        end else if (c == CH_CLOSE_SQUARE) begin
            k = KIND_SQUARE;
        end
        return k;
    endfunction

    // Event code for a top-level group opened with the given kind.
    function automatic t_event open_event(input t_kind k);
        t_event e;
        unique case (k)
            KIND_ROUND:  e = EV_OPEN_ROUND;
            KIND_CURLY:  e = EV_OPEN_CURLY;
            KIND_SQUARE: e = EV_OPEN_SQUARE;
            default:     e = EV_NONE;
        endcase
        return e;
    endfunction

endpackage

// File: sv/bracket_group_extractor.sv
// Bracket group extractor: stack of bracket kinds in a one-port-write memory,
// with the two top entries cached in registers. Depends on bge_pkg.
//
// A result appears in the output register in the cycle after its transfer.
// One item per cycle while the output is not stalled; the top two stack entries live in
// registers and the memory read for the third is registered in advance, so pops never wait.
// Reset (synchronous, active low) empties the stack, clears row, column and the
// error flag, and drops the output register. Stack memory needs no clearing.
module bracket_group_extractor #(
    parameter int STACK_DEPTH = bge_pkg::STACK_DEPTH_DEF,
    parameter int POS_BITS    = bge_pkg::POS_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [bge_pkg::CMD_W-1:0]   i_cmd,
    input  logic [bge_pkg::CHAR_W-1:0]  i_ch,
    // Output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bge_pkg::CHAR_W-1:0]  o_plane_char,
    output logic                        o_plane_valid,
    output logic [bge_pkg::CHAR_W-1:0]  o_content_char,
    output logic                        o_content_valid,
    output logic [bge_pkg::EVENT_W-1:0] o_event_res,
    output logic [bge_pkg::ERR_W-1:0]   o_error_kind,
    output logic [bge_pkg::POS_W-1:0]   o_row,
    output logic [bge_pkg::POS_W-1:0]   o_col,
    output logic                        o_failed
);
    import bge_pkg::*;

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // Stack memory and its registered read data (entry three below the level).
    t_kind            r_mem [STACK_DEPTH];
    t_kind            r_rdata;
    logic [IDX_W-1:0] n_raddr;

    // Control and cached stack state.
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    t_kind               r_top, n_top;
    t_kind               r_below, n_below;
    logic [POS_BITS-1:0] r_row, n_row;
    logic [POS_BITS-1:0] r_col, n_col;
    logic                r_err, n_err;

    // Output register.
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_plane_char, n_plane_char;
    logic              r_plane_valid, n_plane_valid;
    logic [CHAR_W-1:0] r_content_char, n_content_char;
    logic              r_content_valid, n_content_valid;
    t_event            r_event, n_event;
    t_err              r_err_kind, n_err_kind;
    logic [POS_W-1:0]  r_out_row, n_out_row;
    logic [POS_W-1:0]  r_out_col, n_out_col;
    logic              r_out_failed;

    logic             accept;
    logic             push;
    logic             pop;
    t_kind            okind;
    t_kind            ckind;
    logic [LVL_W-1:0] lvl_minus3;

    // Handshake: stall the input only while a finished result is held back.
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign okind = open_kind(i_ch);
    assign ckind = close_kind(i_ch);

    // Item processing: next state and the result of the offered item.
    always_comb begin
        logic fail;
        logic skip_content;
        logic blank;
        fail            = 1'b0;
        skip_content    = 1'b0;
        blank           = 1'b0;
        push            = 1'b0;
        pop             = 1'b0;
        n_lvl           = r_lvl;
        n_top           = r_top;
        n_below         = r_below;
        n_row           = r_row;
        n_col           = r_col;
        n_err           = r_err;
        n_plane_char    = '0;
        n_plane_valid   = 1'b0;
        n_content_char  = '0;
        n_content_valid = 1'b0;
        n_event         = EV_NONE;
        n_err_kind      = ERR_NONE;
        n_out_row       = POS_W'(r_row);
        n_out_col       = POS_W'(r_col);

        unique case (t_cmd'(i_cmd))
            CMD_RESTART: begin
                n_lvl     = '0;
                n_row     = '0;
                n_col     = '0;
                n_err     = 1'b0;
                n_out_row = '0;
                n_out_col = '0;
            end
            CMD_EOL: begin
                if (!r_err) begin
                    if (r_lvl != '0) begin
                        n_content_char  = CH_NEWLINE;
                        n_content_valid = 1'b1;
                    end
                    if (r_row != POS_MAX) begin
                        n_row = r_row + 1'b1;
                    end
                    n_col = '0;
                end
            end
            CMD_CHAR: begin
                if (!r_err) begin
                    if (okind != KIND_NONE) begin
                        if (int'(r_lvl) >= STACK_DEPTH) begin
                            fail       = 1'b1;
                            n_err_kind = ERR_DEEP;
                        end else begin
                            if (r_lvl == '0) begin
                                n_event      = open_event(okind);
                                skip_content = 1'b1;
                            end
                            push = 1'b1;
                        end
                    end else if (ckind != KIND_NONE) begin
                        if (r_lvl == '0 || r_top != ckind) begin
                            fail       = 1'b1;
                            n_err_kind = ERR_MISMATCH;
                        end else begin
                            pop   = 1'b1;
                            blank = 1'b1;
                            if (r_lvl == LVL_W'(1)) begin
                                n_event = EV_CLOSE;
                            end
                        end
                    end

                    // Stack update: the cached entries shift down or up by one.
                    if (push) begin
                        n_lvl   = r_lvl + 1'b1;
                        n_top   = okind;
                        n_below = r_top;
                    end else if (pop) begin
                        n_lvl   = r_lvl - 1'b1;
                        n_top   = r_below;
                        n_below = r_rdata;
                    end

                    if (fail) begin
                        n_err   = 1'b1;
                        n_event = EV_ERROR;
                    end else begin
                        if (n_lvl != '0 && !skip_content) begin
                            n_content_char  = i_ch;
                            n_content_valid = 1'b1;
                        end
                        n_plane_char  = (n_lvl == '0 && !blank) ? i_ch : CH_SPACE;
                        n_plane_valid = 1'b1;
                        if (r_col != POS_MAX) begin
                            n_col = r_col + 1'b1;
                        end
                    end
                end
            end
            default: begin
                // Unused command code: nothing changes.
            end
        endcase
    end

    // Read address for the entry three below the next level.
    assign lvl_minus3 = n_lvl - LVL_W'(3);
    always_comb begin
        if (int'(n_lvl) >= 3) begin
            n_raddr = lvl_minus3[IDX_W-1:0];
        end else begin
            n_raddr = '0;
        end
    end

    // Stack memory: a push writes at the level, the read runs every cycle.
    always_ff @(posedge i_clk) begin
        if (accept && push) begin
            r_mem[r_lvl[IDX_W-1:0]] <= okind;
        end
        r_rdata <= r_mem[accept ? n_raddr : (int'(r_lvl) >= 3 ?
                   IDX_W'(r_lvl - LVL_W'(3)) : IDX_W'(0))];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= '0;
            r_row <= '0;
            r_col <= '0;
            r_err <= 1'b0;
        end else if (accept) begin
            r_lvl <= n_lvl;
            r_row <= n_row;
            r_col <= n_col;
            r_err <= n_err;
        end
    end

    // Cached top entries.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_top   <= n_top;
            r_below <= n_below;
        end
    end

    // Output valid: set on a transfer in, cleared once the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_plane_char    <= n_plane_char;
            r_plane_valid   <= n_plane_valid;
            r_content_char  <= n_content_char;
            r_content_valid <= n_content_valid;
            r_event         <= n_event;
            r_err_kind      <= n_err_kind;
            r_out_row       <= n_out_row;
            r_out_col       <= n_out_col;
            r_out_failed    <= n_err;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_plane_char    = r_plane_char;
    assign o_plane_valid   = r_plane_valid;
    assign o_content_char  = r_content_char;
    assign o_content_valid = r_content_valid;
    assign o_event_res     = r_event;
    assign o_error_kind    = r_err_kind;
    assign o_row           = r_out_row;
    assign o_col           = r_out_col;
    assign o_failed        = r_out_failed;

    // The stack level never exceeds the memory depth.
    a_lvl_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_lvl) <= STACK_DEPTH)
        else $error("stack level beyond depth");

    // A restart transfer empties the stack and clears the error.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_RESTART) |=> (r_lvl == '0 && !r_err))
        else $error("restart did not clear state");

    // While failed, only a restart may move the stack or position.
    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && !(accept && i_cmd == CMD_RESTART))
        |=> ($stable(r_lvl) && $stable(r_row) && $stable(r_col)))
        else $error("state moved while failed");

    // A push raises the level by exactly one.
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && push) |=> (r_lvl == $past(r_lvl) + 1'b1))
        else $error("push did not raise the level");

    // Content or plane data never comes with a failed result.
    a_no_data_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_content_valid || o_plane_valid)) |-> !o_failed)
        else $error("data reported with failed status");

endmodule
